// ===== rtl/bse_pkg.sv =====
package bse_pkg;

  localparam int SampleWidth = 16;
  localparam int QueueDepth  = 4;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          final_item;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sorted_value;
    logic                          end_of_run;
    logic                          overflowed;
  } out_item_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          final_item;
    logic                          keep;
    logic                          overflowed;
  } entry_t;

endpackage

// ===== rtl/bse_front.sv =====
module bse_front #(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bse_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output bse_pkg::entry_t  q_data
);
  import bse_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic          drop;
  logic          room;

  assign room     = count < CW'(CAPACITY);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.sample     = in_data.sample;
    q_data.final_item = in_data.final_item;
    q_data.keep       = room;
    q_data.overflowed = drop || !room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (q_push) begin
      if (in_data.final_item) begin
        count <= '0;
        drop  <= 1'b0;
      end else if (room) begin
        count <= count + CW'(1);
      end else begin
        drop <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bse_queue.sv =====
module bse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bse_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output bse_pkg::entry_t pop_data
);
  import bse_pkg::*;

  localparam int PW = $clog2(QueueDepth);

  entry_t        slots [QueueDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   used;
  logic          do_push;
  logic          do_pop;

  assign full      = used == (PW+1)'(QueueDepth);
  assign not_empty = used != '0;
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        used <= used - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/bse_back.sv =====
module bse_back #(
  parameter int CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  output logic              q_pop,
  input  bse_pkg::entry_t   q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bse_pkg::out_item_t out_data
);
  import bse_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [SampleWidth-1:0] row      [CAPACITY];
  logic signed [SampleWidth-1:0] row_next [CAPACITY];
  logic [CAPACITY-1:0]           stay;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 idx;
  logic                          emitting;
  logic                          ovf;
  logic                          take;
  logic                          emit;
  logic                          is_last;

  // Every bucket index is monotonic in the value, so ordering by bucket and
  // then by value is plain ascending order; the row keeps that order as it
  // fills, one insertion per cycle while it is not emitting.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      stay[i] = (CW'(i) < count) && (row[i] <= q_data.sample);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (stay[i]) begin
        row_next[i] = row[i];
      end else if (i == 0) begin
        row_next[i] = q_data.sample;
      end else if (stay[(i > 0) ? i - 1 : 0]) begin
        row_next[i] = q_data.sample;
      end else begin
        row_next[i] = row[(i > 0) ? i - 1 : 0];
      end
    end
  end

  assign q_pop   = q_not_empty && !emitting;
  assign take    = q_pop;
  assign emit    = emitting && (!out_valid || out_ready);
  assign is_last = idx == count - CW'(1);

  always_ff @(posedge clk) begin
    if (take && q_data.keep) begin
      for (int i = 0; i < CAPACITY; i++) begin
        row[i] <= row_next[i];
      end
    end
    if (emit) begin
      out_data.sorted_value <= row[idx[IW-1:0]];
      out_data.end_of_run   <= is_last;
      out_data.overflowed   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      emitting  <= 1'b0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (q_data.keep) begin
          count <= count + CW'(1);
        end
        if (q_data.final_item) begin
          emitting <= 1'b1;
          idx      <= '0;
          ovf      <= q_data.overflowed;
        end
      end else if (emit) begin
        if (is_last) begin
          emitting <= 1'b0;
          count    <= '0;
        end else begin
          idx <= idx + CW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/bucket_sort_engine_core.sv =====
// Channel | Signals                          | Moves
// input   | in_valid, in_ready, in_data      | one sample per transaction
// output  | out_valid, out_ready, out_data   | one sorted value per transaction
//
// Samples are taken one per cycle while the four-entry queue is not full; the back end
// inserts one per cycle into a sorted register row while it is not emitting, so loading
// runs at one item a cycle. After the final item the back end emits n values at one per
// cycle, during which it takes nothing from the queue; the front keeps filling the queue.
// Reset (rst, synchronous) empties the queue and the row; no clearing pass.
// Out_ready low holds the output register and stalls emission.
module bucket_sort_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bse_pkg::out_item_t out_data
);
  import bse_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_not_empty;
  entry_t q_in;
  entry_t q_out;

  bse_front #(.CAPACITY(CAPACITY)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  bse_back #(.CAPACITY(CAPACITY)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .q_data      (q_out),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== dv/bse_checker.sv =====
module bse_checker #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bse_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bse_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  logic signed [SampleWidth-1:0] set_values[$];
  logic signed [SampleWidth-1:0] set_min;
  logic signed [SampleWidth-1:0] set_max;
  logic                          set_dropped;
  out_item_t                     sorted_queue[$];

  assign pending = sorted_queue.size();

  initial errors = 0;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    errors++;
    $display("%0t: mismatch on %s: got %h/%b/%b, expected %h/%b/%b", $realtime, what,
             got.sorted_value, got.end_of_run, got.overflowed,
             want.sorted_value, want.end_of_run, want.overflowed);
  endtask

  // Bucket index first, then value; the insertion is stable.
  task automatic sort_set();
    int n;
    int unsigned span;
    int unsigned bkt[$];
    int unsigned kb;
    logic signed [SampleWidth-1:0] kv;
    int j;
    out_item_t item;
    n = set_values.size();
    span = int'(set_max) - int'(set_min) + 256;
    for (int i = 0; i < n; i++)
      bkt = {bkt, int'(unsigned'((int'(set_values[i]) - int'(set_min)) * n) / span)};
    for (int i = 1; i < n; i++) begin
      kv = set_values[i];
      kb = bkt[i];
      j = i;
      while (j > 0 && (bkt[j-1] > kb || (bkt[j-1] == kb && set_values[j-1] > kv))) begin
        set_values[j] = set_values[j-1];
        bkt[j] = bkt[j-1];
        j--;
      end
      set_values[j] = kv;
      bkt[j] = kb;
    end
    for (int i = 0; i < n; i++) begin
      item.sorted_value = set_values[i];
      item.end_of_run   = (i == n - 1);
      item.overflowed   = set_dropped;
      sorted_queue = {sorted_queue, item};
    end
  endtask

  task automatic clear_set();
    set_values.delete();
    set_min = 16'sh7FFF;
    set_max = -16'sh8000;
    set_dropped = 1'b0;
  endtask

  out_item_t want;

  always @(posedge clk) begin
    if (rst) begin
      clear_set();
      sorted_queue.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (set_values.size() < CAPACITY) begin
          set_values = {set_values, in_data.sample};
          if (in_data.sample < set_min) set_min = in_data.sample;
          if (in_data.sample > set_max) set_max = in_data.sample;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_data.final_item) begin
          sort_set();
          clear_set();
        end
      end
      if (out_valid && out_ready) begin
        if (sorted_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $realtime, out_data.sorted_value);
        end else begin
          want = sorted_queue.pop_front();
          if (out_data.sorted_value !== want.sorted_value) report("sorted_value", out_data, want);
          if (out_data.end_of_run !== want.end_of_run) report("end_of_run", out_data, want);
          if (out_data.overflowed !== want.overflowed) report("overflowed", out_data, want);
        end
      end
    end
  end

endmodule

// ===== dv/bucket_sort_engine_core_tb.sv =====
module bucket_sort_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam int Capacity = 32;
  localparam int StallLimit = 4000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors;
  int        pending;
  bit        hold_output = 1'b0;
  bit        steady = 1'b0;
  int        sent = 0;

  bucket_sort_engine_core #(.CAPACITY(Capacity)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  bse_checker #(.CAPACITY(Capacity)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random backpressure, with a long hold-off on request.
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk);
        hold_output = 1'b0;
      end
      out_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // Watchdog on cycles where neither channel moves a transaction.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send(input logic signed [15:0] value, input logic last);
    in_valid <= 1'b1;
    in_data.sample <= value;
    in_data.final_item <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_set();
    int n;
    int mode;
    int base;
    int spread;
    logic signed [15:0] v;
    mode = $urandom_range(9);
    if (mode < 6) n = $urandom_range(1, 12);
    else if (mode < 8) n = $urandom_range(13, Capacity);
    else n = $urandom_range(Capacity + 1, Capacity + 8);
    mode = $urandom_range(3);
    base = $urandom_range(65535) - 32768;
    spread = (mode == 1) ? $urandom_range(1, 600) : $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if (mode == 0 || mode == 3) v = 16'($urandom());
      else v = 16'(base + $urandom_range(spread));
      send(v, i == n - 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-item sets at the extremes.
    send(16'sh7FFF, 1'b1);
    send(-16'sh8000, 1'b1);
    // Both extremes together with zero and repeated values.
    send(16'sh0000, 1'b0);
    send(16'sh7FFF, 1'b0);
    send(-16'sh8000, 1'b0);
    send(16'sh0100, 1'b0);
    send(16'sh0100, 1'b0);
    send(-16'sh0001, 1'b1);
    // All values equal.
    for (int i = 0; i < 4; i++) send(16'sh1234, i == 3);
    drain();
    // Over capacity; the final item itself is dropped.
    for (int i = 0; i < Capacity + 3; i++) send(16'(Capacity - i), i == Capacity + 2);
    drain();

    while (sent < 500) begin
      steady = (sent >= 150 && sent < 260);
      if (sent >= 300 && sent < 340 && !hold_output) hold_output = 1'b1;
      random_set();
      if ($urandom_range(9) == 0) drain();
    end
    steady = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
